>>> rtl/oad_pkg.sv
// oversampled ADC decimator: shared types, constants and the pin map
// no dependencies; imported by every module of the block
package oad_pkg;

   localparam int PINS_PER_FRAME = 8;
   localparam int MAX_RATIO      = 49;

   localparam int NAXES    = 6;
   localparam int SAMPLE_W = 12;
   localparam int CH_W     = 3;
   localparam int AXIS_W   = 3;
   localparam int RATIO_W  = 6;
   localparam int SUM_W    = 18;
   localparam int COEF_W   = 64;
   localparam int HALF_W   = 32;
   localparam int IDX_W    = 3;
   // product of sum and scale magnitude, then dividend after the divide by 256
   localparam int PROD_W   = SUM_W + HALF_W;
   localparam int QUO_W    = PROD_W - 9;
   localparam int CNT_W    = $clog2(QUO_W);
   localparam int VAL_W    = QUO_W + 3;

   localparam logic [CH_W-1:0] LAST_PIN =
      (PINS_PER_FRAME - 1 > 7) ? CH_W'(7) : CH_W'(PINS_PER_FRAME - 1);
   localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(MAX_RATIO);
   localparam logic [RATIO_W-1:0] RATIO_MIN = RATIO_W'(1);
   localparam logic [AXIS_W-1:0]  AXIS_LAST = AXIS_W'(NAXES - 1);

   localparam logic [IDX_W-1:0] REG_RATIO     = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_CAL_FIRST = IDX_W'(1);
   localparam logic [IDX_W-1:0] REG_CAL_LAST  = IDX_W'(6);

   localparam logic signed [VAL_W-1:0] VAL_MAX = VAL_W'(64'sd2147483647);
   localparam logic signed [VAL_W-1:0] VAL_MIN = VAL_W'(-64'sd2147483648);

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [CH_W-1:0]     channel;
   } req_type;

   typedef struct packed {
      logic [AXIS_W-1:0]        axis;
      logic signed [HALF_W-1:0] value;
      logic [SAMPLE_W-1:0]      first_raw;
      logic                     last;
   } rsp_type;

   // block end strobe with the sums and first samples including that transfer
   typedef struct packed {
      logic                                done;
      logic [NAXES-1:0][SUM_W-1:0]         sums;
      logic [NAXES-1:0][SAMPLE_W-1:0]      firsts;
   } blk_type;

   typedef struct packed {
      logic                start;
      logic [SUM_W-1:0]    sum;
      logic [COEF_W-1:0]   coef;
      logic [RATIO_W-1:0]  ratio;
   } cal_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [HALF_W-1:0] value;
   } cal_rsp_type;

   typedef enum logic [2:0] {
      CAL_IDLE,
      CAL_MUL,
      CAL_RND,
      CAL_DIV,
      CAL_FIN
   } cal_phase_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_START,
      SEQ_CALC,
      SEQ_EMIT
   } seq_state_type;

   // ADC pin that carries each axis
   function automatic logic [CH_W-1:0] axis_pin(input logic [AXIS_W-1:0] axis);
      logic [CH_W-1:0] pin;
      case (axis)
         3'd0:    pin = 3'd2;
         3'd1:    pin = 3'd0;
         3'd2:    pin = 3'd4;
         3'd3:    pin = 3'd1;
         3'd4:    pin = 3'd3;
         3'd5:    pin = 3'd5;
         default: pin = 3'd0;
      endcase
      return pin;
   endfunction

endpackage

>>> rtl/oad_accum.sv
// per-pin boxcar accumulators, first-sample capture and frame counting
// depends on oad_pkg
module oad_accum
   import oad_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  req_type            item,
   input  logic [RATIO_W-1:0] ratio,
   output blk_type            blk
);

   logic [NAXES-1:0][SUM_W-1:0]    sums_ff;
   logic [NAXES-1:0][SAMPLE_W-1:0] first_ff;
   logic [RATIO_W-1:0]             frame_ff;
   logic [RATIO_W-1:0]             frame_in;
   logic [RATIO_W-1:0]             frame_inc;
   logic                           frame_end;

   always_comb begin
      for (int i = 0; i < NAXES; i++) begin
         if (take && item.channel == CH_W'(i)) begin
            blk.sums[i] = sums_ff[i] + SUM_W'(item.sample);
            blk.firsts[i] = (frame_ff == '0) ? item.sample : first_ff[i];
         end else begin
            blk.sums[i] = sums_ff[i];
            blk.firsts[i] = first_ff[i];
         end
      end
      frame_end = take && item.channel == LAST_PIN;
      frame_inc = frame_ff + RATIO_W'(1);
      blk.done  = frame_end && frame_inc >= ratio;
      if (blk.done) begin
         frame_in = '0;
      end else if (frame_end) begin
         frame_in = frame_inc;
      end else begin
         frame_in = frame_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff  <= '0;
         first_ff <= '0;
         frame_ff <= '0;
      end else begin
         sums_ff  <= blk.done ? '0 : blk.sums;
         first_ff <= blk.firsts;
         frame_ff <= frame_in;
      end
   end

endmodule

>>> rtl/oad_cal.sv
// bit-serial calibration unit: shift-add multiply, rounding, restoring divide,
// sign, bias and saturation for one axis at a time; depends on oad_pkg
module oad_cal
   import oad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cal_req_type req,
   output cal_rsp_type rsp
);

   cal_phase_type            phase_ff, phase_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [HALF_W-1:0]        hi_ff, hi_in;
   logic [SUM_W-1:0]         mq_ff, mq_in;
   logic [QUO_W-1:0]         dq_ff, dq_in;
   logic [RATIO_W-1:0]       rem_ff, rem_in;
   logic [HALF_W-1:0]        smag_ff, smag_in;
   logic                     sneg_ff, sneg_in;
   logic [HALF_W-1:0]        bias_ff, bias_in;
   logic [RATIO_W-1:0]       ratio_ff, ratio_in;

   logic [HALF_W:0]          hs;
   logic [PROD_W-1:0]        rs;
   logic [RATIO_W:0]         trial;
   logic                     ge;
   logic signed [VAL_W-1:0]  vq;
   logic signed [VAL_W-1:0]  vs;
   logic signed [VAL_W-1:0]  vb;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         CAL_IDLE: if (req.start) phase_in = CAL_MUL;
         CAL_MUL:  if (cnt_ff == CNT_W'(SUM_W - 1)) phase_in = CAL_RND;
         CAL_RND:  phase_in = CAL_DIV;
         CAL_DIV:  if (cnt_ff == CNT_W'(QUO_W - 1)) phase_in = CAL_FIN;
         CAL_FIN:  phase_in = CAL_IDLE;
         default:  phase_in = CAL_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rsp.done = (phase_ff == CAL_FIN);
      vq = VAL_W'(dq_ff);
      vs = sneg_ff ? -vq : vq;
      vb = vs + VAL_W'(signed'(bias_ff));
      if (vb > VAL_MAX) begin
         rsp.value = HALF_W'(VAL_MAX);
      end else if (vb < VAL_MIN) begin
         rsp.value = HALF_W'(VAL_MIN);
      end else begin
         rsp.value = HALF_W'(vb);
      end
   end

   // datapath
   always_comb begin
      cnt_in   = cnt_ff;
      hi_in    = hi_ff;
      mq_in    = mq_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      smag_in  = smag_ff;
      sneg_in  = sneg_ff;
      bias_in  = bias_ff;
      ratio_in = ratio_ff;
      hs    = {1'b0, hi_ff} + (mq_ff[0] ? {1'b0, smag_ff} : '0);
      rs    = {hi_ff, mq_ff} + PROD_W'({ratio_ff, 7'b0});
      trial = {rem_ff, dq_ff[QUO_W-1]};
      ge    = trial >= {1'b0, ratio_ff};
      case (phase_ff)
         CAL_IDLE: begin
            if (req.start) begin
               sneg_in  = req.coef[COEF_W-1];
               smag_in  = req.coef[COEF_W-1] ? -req.coef[COEF_W-1:HALF_W]
                                             : req.coef[COEF_W-1:HALF_W];
               bias_in  = req.coef[HALF_W-1:0];
               ratio_in = req.ratio;
               hi_in    = '0;
               mq_in    = req.sum;
               cnt_in   = '0;
            end
         end
         CAL_MUL: begin
            hi_in  = hs[HALF_W:1];
            mq_in  = {hs[0], mq_ff[SUM_W-1:1]};
            cnt_in = (cnt_ff == CNT_W'(SUM_W - 1)) ? '0 : cnt_ff + CNT_W'(1);
         end
         CAL_RND: begin
            // add half the divisor, drop the 256 of the Q8.24 to Q16.16 step
            dq_in  = rs[PROD_W-2:8];
            rem_in = '0;
            cnt_in = '0;
         end
         CAL_DIV: begin
            rem_in = ge ? RATIO_W'(trial - {1'b0, ratio_ff}) : trial[RATIO_W-1:0];
            dq_in  = {dq_ff[QUO_W-2:0], ge};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= CAL_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      cnt_ff   <= cnt_in;
      hi_ff    <= hi_in;
      mq_ff    <= mq_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      smag_ff  <= smag_in;
      sneg_ff  <= sneg_in;
      bias_ff  <= bias_in;
      ratio_ff <= ratio_in;
   end

endmodule

>>> rtl/oversampled_adc_decimator.sv
// Boxcar decimator for interleaved ADC samples. When a block of frames ends, the
// six axis results are worked out one after another by a bit-serial unit: 18
// multiply steps, one rounding step, 41 divide steps and one bias and
// saturation step per axis. Samples keep flowing while that runs, but a
// frame-end sample is stalled until the last result of the previous block has
// been loaded into the output register.
// top level; depends on oad_pkg, oad_accum and oad_cal
module oversampled_adc_decimator
   import oad_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [COEF_W-1:0] csr_data
);

   logic [RATIO_W-1:0]              ratio_ff;
   logic [NAXES-1:0][COEF_W-1:0]    cal_ff;
   logic [RATIO_W-1:0]              ratio_eff;

   seq_state_type                   seq_ff, seq_in;
   logic [AXIS_W-1:0]               axis_ff;
   logic [NAXES-1:0][SUM_W-1:0]     snap_sum_ff;
   logic [NAXES-1:0][SAMPLE_W-1:0]  snap_first_ff;
   logic signed [HALF_W-1:0]        res_ff;
   logic                            rsp_valid_ff;
   rsp_type                         rsp_data_ff;

   logic                            take;
   logic                            busy;
   logic                            slot_free;
   logic                            emit;
   blk_type                         blk;
   cal_req_type                     cal_req;
   cal_rsp_type                     cal_rsp;

   always_comb begin
      if (ratio_ff == '0) begin
         ratio_eff = RATIO_MIN;
      end else if (ratio_ff > RATIO_MAX) begin
         ratio_eff = RATIO_MAX;
      end else begin
         ratio_eff = ratio_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= RATIO_W'(17);
         cal_ff   <= '0;
      end else if (csr_we) begin
         if (csr_index == REG_RATIO) begin
            ratio_ff <= csr_data[RATIO_W-1:0];
         end else if (csr_index inside {[REG_CAL_FIRST:REG_CAL_LAST]}) begin
            cal_ff[csr_index - REG_CAL_FIRST] <= csr_data;
         end
      end
   end

   assign busy      = (seq_ff != SEQ_IDLE);
   assign req_stall = busy && req_data.channel == LAST_PIN;
   assign take      = req_valid && !req_stall;

   oad_accum u_accum (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .item  (req_data),
      .ratio (ratio_eff),
      .blk   (blk)
   );

   oad_cal u_cal (
      .clock (clock),
      .reset (reset),
      .req   (cal_req),
      .rsp   (cal_rsp)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SEQ_IDLE:  if (blk.done) seq_in = SEQ_START;
         SEQ_START: seq_in = SEQ_CALC;
         SEQ_CALC:  if (cal_rsp.done) seq_in = SEQ_EMIT;
         SEQ_EMIT: begin
            if (slot_free) begin
               seq_in = (axis_ff == AXIS_LAST) ? SEQ_IDLE : SEQ_START;
            end
         end
         default:   seq_in = SEQ_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cal_req.start = (seq_ff == SEQ_START);
      cal_req.sum   = snap_sum_ff[0];
      cal_req.coef  = cal_ff[axis_ff];
      cal_req.ratio = ratio_eff;
      emit          = (seq_ff == SEQ_EMIT) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         if (blk.done) begin
            axis_ff <= '0;
         end else if (emit) begin
            axis_ff <= axis_ff + AXIS_W'(1);
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // snapshot line in axis order, head is the axis in work
   always_ff @(posedge clock) begin
      if (blk.done) begin
         for (int k = 0; k < NAXES; k++) begin
            snap_sum_ff[k]   <= blk.sums[axis_pin(AXIS_W'(k))];
            snap_first_ff[k] <= blk.firsts[axis_pin(AXIS_W'(k))];
         end
      end else if (emit) begin
         for (int k = 0; k < NAXES - 1; k++) begin
            snap_sum_ff[k]   <= snap_sum_ff[k+1];
            snap_first_ff[k] <= snap_first_ff[k+1];
         end
      end
      if (cal_rsp.done) begin
         res_ff <= cal_rsp.value;
      end
      if (emit) begin
         rsp_data_ff.axis      <= axis_ff;
         rsp_data_ff.value     <= res_ff;
         rsp_data_ff.first_raw <= snap_first_ff[0];
         rsp_data_ff.last      <= (axis_ff == AXIS_LAST);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_no_frame_end_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !(take && req_data.channel == LAST_PIN))
      else $error("frame end transfer taken while results are in work");

   a_cal_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      cal_rsp.done |-> seq_ff == SEQ_CALC)
      else $error("calibration finished outside its sequencer state");

   a_last_on_final_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.last == (rsp_data.axis == AXIS_LAST))
      else $error("last flag does not match the final axis");

   a_emit_advances_axis: assert property (@(posedge clock) disable iff (reset)
      emit && axis_ff != AXIS_LAST |=> axis_ff == $past(axis_ff) + AXIS_W'(1))
      else $error("axis counter did not step after a result");
`endif

endmodule
